// ===== rtl/sample_store_mean_distance_evict_unit_defines.svh =====
// assertion macros for the sample store rtl
`ifndef SAMPLE_STORE_MEAN_DISTANCE_EVICT_UNIT_DEFINES_SVH
`define SAMPLE_STORE_MEAN_DISTANCE_EVICT_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define SSMDE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define SSMDE_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ssmde_pkg.sv =====
// package: field widths, record layout, microcode table of the sample store
package ssmde_pkg;

  localparam int DEPTH_DEF = 512;
  localparam int VAL_W     = 12;
  localparam int STAMP_W   = 32;
  localparam int SLOT_W    = 9;
  localparam int COUNT_W   = 10;

  typedef struct packed {
    logic               button;
    logic [STAMP_W-1:0] stamp;
    logic [VAL_W-1:0]   value;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // request function codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // microcode steps
  localparam int PC_W = 4;
  localparam logic [PC_W-1:0] S_IDLE     = 4'd0;
  localparam logic [PC_W-1:0] S_RDREQ    = 4'd1;
  localparam logic [PC_W-1:0] S_BRANCH   = 4'd2;
  localparam logic [PC_W-1:0] S_UPDATE   = 4'd3;
  localparam logic [PC_W-1:0] S_MEANEST  = 4'd4;
  localparam logic [PC_W-1:0] S_MEANFIX  = 4'd5;
  localparam logic [PC_W-1:0] S_SCANINIT = 4'd6;
  localparam logic [PC_W-1:0] S_SCAN     = 4'd7;
  localparam logic [PC_W-1:0] S_VICTIM   = 4'd8;
  localparam logic [PC_W-1:0] S_RESULT   = 4'd9;

  // datapath operations
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LATCH    = 4'd1;
  localparam logic [3:0] OP_RAMRD    = 4'd2;
  localparam logic [3:0] OP_UPDATE   = 4'd3;
  localparam logic [3:0] OP_MEANEST  = 4'd4;
  localparam logic [3:0] OP_MEANFIX  = 4'd5;
  localparam logic [3:0] OP_SCANINIT = 4'd6;
  localparam logic [3:0] OP_SCAN     = 4'd7;
  localparam logic [3:0] OP_VICTIM   = 4'd8;
  localparam logic [3:0] OP_RESULT   = 4'd9;

  // jump conditions
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_ACCEPT    = 3'd2;
  localparam logic [2:0] C_IS_READ   = 3'd3;
  localparam logic [2:0] C_NOT_FULL  = 3'd4;
  localparam logic [2:0] C_SCAN_MORE = 3'd6;
  localparam logic [2:0] C_OUT_FREE  = 3'd7;

  typedef struct packed {
    logic [3:0]      op;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
    logic            hold;    // stay on this step while the condition is false
  } ctrl_word_t;

  typedef struct packed {
    logic accept;
    logic is_read;
    logic not_full;
    logic scan_more;
    logic out_free;
  } stat_t;

  function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    case (pc)
      S_IDLE:     w = '{op: OP_LATCH,    cond: C_ACCEPT,    target: S_RDREQ,   hold: 1'b1};
      S_RDREQ:    w = '{op: OP_RAMRD,    cond: C_NEVER,     target: S_IDLE,    hold: 1'b0};
      S_BRANCH:   w = '{op: OP_NONE,     cond: C_IS_READ,   target: S_RESULT,  hold: 1'b0};
      S_UPDATE:   w = '{op: OP_UPDATE,   cond: C_NEVER,     target: S_IDLE,    hold: 1'b0};
      S_MEANEST:  w = '{op: OP_MEANEST,  cond: C_NOT_FULL,  target: S_RESULT,  hold: 1'b0};
      S_MEANFIX:  w = '{op: OP_MEANFIX,  cond: C_NEVER,     target: S_IDLE,    hold: 1'b0};
      S_SCANINIT: w = '{op: OP_SCANINIT, cond: C_NEVER,     target: S_IDLE,    hold: 1'b0};
      S_SCAN:     w = '{op: OP_SCAN,     cond: C_SCAN_MORE, target: S_SCAN,    hold: 1'b0};
      S_VICTIM:   w = '{op: OP_VICTIM,   cond: C_NEVER,     target: S_IDLE,    hold: 1'b0};
      S_RESULT:   w = '{op: OP_RESULT,   cond: C_OUT_FREE,  target: S_IDLE,    hold: 1'b1};
      default:    w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_IDLE,    hold: 1'b0};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/ssmde_req_if.sv =====
// request channel interface of the sample store
interface ssmde_req_if;
  import ssmde_pkg::*;

  logic               valid;
  logic               ready;
  logic               func;
  logic [VAL_W-1:0]   sample_value;
  logic               button_state;
  logic [STAMP_W-1:0] stamp;
  logic [SLOT_W-1:0]  read_slot;

  modport source (output valid, func, sample_value, button_state, stamp, read_slot,
                  input ready);
  modport sink   (input valid, func, sample_value, button_state, stamp, read_slot,
                  output ready);
endinterface

// ===== rtl/ssmde_rsp_if.sv =====
// response channel interface of the sample store
interface ssmde_rsp_if;
  import ssmde_pkg::*;

  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  slot_written;
  logic [SLOT_W-1:0]  next_slot;
  logic               store_full;
  logic [COUNT_W-1:0] entry_count;
  logic [VAL_W-1:0]   read_value;
  logic               read_button;
  logic [STAMP_W-1:0] read_stamp;

  modport source (output valid, slot_written, next_slot, store_full, entry_count,
                  read_value, read_button, read_stamp,
                  input ready);
  modport sink   (input valid, slot_written, next_slot, store_full, entry_count,
                  read_value, read_button, read_stamp,
                  output ready);
endinterface

// ===== rtl/ssmde_ram.sv =====
// generic single-write, single-read ram with registered read data
module ssmde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ssmde_seq.sv =====
// microcode sequencer: step counter, control rom and conditional jumps
module ssmde_seq (
  input  logic                    clk,
  input  logic                    rst,
  input  ssmde_pkg::stat_t        stat,
  output ssmde_pkg::ctrl_word_t   ctl
);
  import ssmde_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            take;

  assign ctl = ucode(pc);

  always_comb begin
    case (ctl.cond)
      C_NEVER:     take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_ACCEPT:    take = stat.accept;
      C_IS_READ:   take = stat.is_read;
      C_NOT_FULL:  take = stat.not_full;
      C_SCAN_MORE: take = stat.scan_more;
      C_OUT_FREE:  take = stat.out_free;
      default:     take = 1'b0;
    endcase
  end

  always_comb begin
    if (take) begin
      pc_next = ctl.target;
    end else if (ctl.hold) begin
      pc_next = pc;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ===== rtl/sample_store_mean_distance_evict_unit.sv =====
// top level: sample record store with mean-distance slot replacement
// steps from accept to result load: a read takes ram read, branch, result; an insert
// while filling adds update and mean estimate; an insert once full also runs the two-step mean
//   estimate and the one-slot-per-cycle scan over the record ram, then the victim step
// flow: one request in flight, the next is taken in the cycle after its result is
//   loaded, even while that result still waits in the output reg
// rst (sync): empty store, write slot 0, sum 0; the record ram itself is not cleared
module sample_store_mean_distance_evict_unit #(
  parameter int DEPTH = ssmde_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  ssmde_req_if.sink   req,
  ssmde_rsp_if.source rsp
);
  import ssmde_pkg::*;

  `include "sample_store_mean_distance_evict_unit_defines.svh"

  localparam int AW      = $clog2(DEPTH);
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int SUM_W   = VAL_W + $clog2(DEPTH);
  localparam int RECIP_W = VAL_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  // floor(2^SUM_W / DEPTH): sum * RECIP >> SUM_W is the mean or one below it
  localparam longint RECIP_L = (longint'(1) << SUM_W) / longint'(DEPTH);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

  // sequencer handshake
  ctrl_word_t ctl;
  stat_t      stat;

  // latched request
  logic               r_func;
  logic [VAL_W-1:0]   r_value;
  logic               r_button;
  logic [STAMP_W-1:0] r_stamp;
  logic [SLOT_W-1:0]  r_rslot;

  // store bookkeeping
  logic [AW-1:0]    write_slot;
  logic [AW-1:0]    slot_wr;
  logic [CW-1:0]    fill_count;
  logic [CW-1:0]    fill_next;
  logic [SUM_W-1:0] sample_sum;
  logic [SUM_W-1:0] sum_next;

  // record ram
  logic          ram_we;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_wdata;
  rec_t          ram_rdata;

  // mean: reciprocal estimate, then one correction against the remainder
  logic [PROD_W-1:0] mean_prod;
  logic [VAL_W-1:0]  mean_est;
  logic [SUM_W-1:0]  mean_back;
  logic [SUM_W-1:0]  mean_rem;
  logic              mean_over;
  logic [VAL_W-1:0]  mean_q;
  logic              mean_frac;

  // victim scan
  logic [AW-1:0]    scan_idx;
  logic [AW-1:0]    best_slot;
  logic [VAL_W-1:0] best_dist;
  logic [VAL_W-1:0] slot_gap;
  logic             scan_more;

  // result register
  logic out_valid;
  logic out_free;
  logic rd_ok;

  ssmde_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  ssmde_ram #(
    .WIDTH (REC_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // requests are only taken on the idle step
  assign req.ready = (ctl.op == OP_LATCH);

  assign out_free  = !out_valid || rsp.ready;
  assign scan_more = int'(scan_idx) != DEPTH - 1;

  assign stat.accept    = req.valid && req.ready;
  assign stat.is_read   = (r_func == FUNC_READ);
  assign stat.not_full  = int'(fill_count) < DEPTH;
  assign stat.scan_more = scan_more;
  assign stat.out_free  = out_free;

  // ram read port: request slot, then the scan walks one slot ahead of the compare
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (ctl.op)
      OP_RAMRD: begin
        ram_re    = 1'b1;
        ram_raddr = (r_func == FUNC_READ) ? AW'(r_rslot) : write_slot;
      end
      OP_SCANINIT: begin
        ram_re    = 1'b1;
        ram_raddr = '0;
      end
      OP_SCAN: begin
        ram_re    = scan_more;
        ram_raddr = scan_idx + 1'b1;
      end
      default: begin
        ram_re    = 1'b0;
        ram_raddr = '0;
      end
    endcase
  end

  assign ram_we    = (ctl.op == OP_UPDATE);
  assign ram_wdata = '{button: r_button, stamp: r_stamp, value: r_value};

  // running sum drops the overwritten sample once the slot held a valid record
  always_comb begin
    sum_next = sample_sum + SUM_W'(r_value);
    if (int'(write_slot) < int'(fill_count)) begin
      sum_next = sum_next - SUM_W'(ram_rdata.value);
    end
    fill_next = (int'(fill_count) < DEPTH) ? fill_count + 1'b1 : fill_count;
  end

  // estimate is low by at most one, so the remainder lies below 2*DEPTH
  assign mean_prod = PROD_W'(sample_sum) * PROD_W'(RECIP);
  assign mean_back = SUM_W'(mean_est) * SUM_W'(DEPTH);
  assign mean_rem  = sample_sum - mean_back;
  assign mean_over = mean_rem >= SUM_W'(DEPTH);

  // floor(|v*DEPTH - sum| / DEPTH) from sum = q*DEPTH + r
  always_comb begin
    if (ram_rdata.value > mean_q) begin
      slot_gap = ram_rdata.value - mean_q - VAL_W'(mean_frac);
    end else begin
      slot_gap = mean_q - ram_rdata.value;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
      sample_sum <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.op == OP_UPDATE) begin
        sample_sum <= sum_next;
        fill_count <= fill_next;
        if (int'(fill_next) < DEPTH) begin
          write_slot <= write_slot + 1'b1;
        end
      end
      if (ctl.op == OP_VICTIM) begin
        write_slot <= best_slot;
      end
      if (ctl.op == OP_RESULT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request capture and datapath registers
  always_ff @(posedge clk) begin
    if (stat.accept) begin
      r_func   <= req.func;
      r_value  <= req.sample_value;
      r_button <= req.button_state;
      r_stamp  <= req.stamp;
      r_rslot  <= req.read_slot;
    end
    if (ctl.op == OP_UPDATE) begin
      slot_wr <= write_slot;
    end
    case (ctl.op)
      OP_MEANEST: begin
        mean_est <= mean_prod[SUM_W +: VAL_W];
      end
      OP_MEANFIX: begin
        mean_q    <= mean_over ? mean_est + 1'b1 : mean_est;
        mean_frac <= mean_over ? (mean_rem != SUM_W'(DEPTH)) : (mean_rem != '0);
      end
      OP_SCANINIT: begin
        scan_idx <= '0;
      end
      OP_SCAN: begin
        // later slots win ties
        if (scan_idx == '0 || slot_gap <= best_dist) begin
          best_slot <= scan_idx;
          best_dist <= slot_gap;
        end
        scan_idx <= scan_idx + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result register
  assign rd_ok = int'(r_rslot) < int'(fill_count) && int'(r_rslot) < DEPTH;

  always_ff @(posedge clk) begin
    if (ctl.op == OP_RESULT && out_free) begin
      rsp.slot_written <= (r_func == FUNC_READ) ? '0 : SLOT_W'(slot_wr);
      rsp.next_slot    <= SLOT_W'(write_slot);
      rsp.store_full   <= int'(fill_count) >= DEPTH;
      rsp.entry_count  <= COUNT_W'(fill_count);
      if (r_func == FUNC_READ && rd_ok) begin
        rsp.read_value  <= ram_rdata.value;
        rsp.read_button <= ram_rdata.button;
        rsp.read_stamp  <= ram_rdata.stamp;
      end else begin
        rsp.read_value  <= '0;
        rsp.read_button <= 1'b0;
        rsp.read_stamp  <= '0;
      end
    end
  end

  assign rsp.valid = out_valid;

  `SSMDE_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, int'(fill_count) <= DEPTH, "fill count above depth")
  `SSMDE_ASSERT_IMP(a_slot_bound, clk, rst, 1'b1, int'(write_slot) < DEPTH, "write slot out of range")
  `SSMDE_ASSERT_IMP(a_fill_order, clk, rst, int'(fill_count) < DEPTH, int'(write_slot) == int'(fill_count), "write slot off fill order")
  `SSMDE_ASSERT_NEXT(a_accept_rd, clk, rst, stat.accept, ctl.op == OP_RAMRD, "accept not followed by ram read")

endmodule

// ===== tb/ssmde_checker.sv =====
// checker for the sample store: predicts every response and compares it with the rtl
`timescale 1ns / 100ps
module ssmde_checker #(
  parameter int DEPTH = ssmde_pkg::DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  ssmde_req_if req,
  ssmde_rsp_if rsp,
  output int   mismatch_count,
  output int   responses_owed
);
  import ssmde_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot_written;
    logic [SLOT_W-1:0]  next_slot;
    logic               store_full;
    logic [COUNT_W-1:0] entry_count;
    logic [VAL_W-1:0]   read_value;
    logic               read_button;
    logic [STAMP_W-1:0] read_stamp;
  } response_t;

  rec_t        records [DEPTH];
  int unsigned write_ptr;
  int unsigned filled;
  int unsigned running_sum;
  response_t   owed_responses [$];
  int          fails = 0;

  // last slot whose sample is nearest the mean, distance floor(|v*DEPTH - sum| / DEPTH)
  function automatic int unsigned closest_to_mean();
    int unsigned best_slot;
    int unsigned best_dist;
    int unsigned slot_gap;
    longint      diff;
    best_slot = 0;
    best_dist = 0;
    for (int i = 0; i < DEPTH; i++) begin
      diff = longint'(records[i].value) * DEPTH - longint'(running_sum);
      if (diff < 0) diff = -diff;
      slot_gap = int'(diff / DEPTH);
      if (i == 0 || slot_gap <= best_dist) begin
        best_slot = i;
        best_dist = slot_gap;
      end
    end
    return best_slot;
  endfunction

  function automatic response_t apply_to_store(input logic func,
                                               input logic [VAL_W-1:0] value,
                                               input logic button,
                                               input logic [STAMP_W-1:0] stamp,
                                               input logic [SLOT_W-1:0] slot);
    response_t   r;
    int unsigned target;
    r = '0;
    if (func == FUNC_INSERT) begin
      target = (write_ptr >= DEPTH) ? 0 : write_ptr;
      // overwrite drops the old sample from the sum
      if (target < filled) running_sum -= records[target].value;
      records[target] = '{button: button, stamp: stamp, value: value};
      running_sum += value;
      if (filled < DEPTH) filled++;
      write_ptr = (filled >= DEPTH) ? closest_to_mean() : target + 1;
      r.slot_written = SLOT_W'(target);
    end else if (slot < filled && slot < DEPTH) begin
      r.read_value  = records[slot].value;
      r.read_button = records[slot].button;
      r.read_stamp  = records[slot].stamp;
    end
    r.next_slot   = SLOT_W'(write_ptr);
    r.store_full  = (filled >= DEPTH);
    r.entry_count = COUNT_W'(filled);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want_v,
                                      input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, actual %0h", name, want_v, got_v);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (rst) begin
      write_ptr   = 0;
      filled      = 0;
      running_sum = 0;
      owed_responses.delete();
      for (int i = 0; i < DEPTH; i++) records[i] = '0;
    end else begin
      // response first: it belongs to a request taken at an earlier edge
      if (rsp.valid && rsp.ready) begin
        if (owed_responses.size() == 0) begin
          $error("response with no request outstanding");
          fails++;
        end else begin
          want = owed_responses.pop_front();
          check_field("slot_written", want.slot_written, rsp.slot_written);
          check_field("next_slot", want.next_slot, rsp.next_slot);
          check_field("store_full", want.store_full, rsp.store_full);
          check_field("entry_count", want.entry_count, rsp.entry_count);
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("read_button", want.read_button, rsp.read_button);
          check_field("read_stamp", want.read_stamp, rsp.read_stamp);
        end
      end
      if (req.valid && req.ready)
        owed_responses.push_back(apply_to_store(req.func, req.sample_value,
                                                req.button_state, req.stamp,
                                                req.read_slot));
    end
    responses_owed <= owed_responses.size();
    mismatch_count <= fails;
  end

endmodule

// ===== tb/tb_top.sv =====
// testbench top for the sample store: stimulus, handshake idling and the verdict
`timescale 1ns / 100ps
module tb_top;
  import ssmde_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int RANDOM_REQS = 940;

  logic clk;
  logic rst;
  int   mismatch_count;
  int   responses_owed;
  bit   send_calm;

  ssmde_req_if req_ch ();
  ssmde_rsp_if rsp_ch ();

  sample_store_mean_distance_evict_unit #(.DEPTH(DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // watches both channels, owns the prediction
  ssmde_checker #(.DEPTH(DEPTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .responses_owed (responses_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.func         = FUNC_INSERT;
    req_ch.sample_value = '0;
    req_ch.button_state = 1'b0;
    req_ch.stamp        = '0;
    req_ch.read_slot    = '0;
    rsp_ch.ready        = 1'b0;
  end

  // hard stop, set at several times the slowest legal run
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // one request: random idle gap, then hold valid until ready is seen at an edge.
  // a zero gap keeps valid high into the next request with a single assignment
  task automatic send_request(input logic func, input logic [VAL_W-1:0] value,
                              input logic button, input logic [STAMP_W-1:0] stamp,
                              input logic [SLOT_W-1:0] slot);
    int gap;
    if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
    gap = send_calm ? 0 : $urandom_range(0, 13);
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.func         <= func;
    req_ch.sample_value <= value;
    req_ch.button_state <= button;
    req_ch.stamp        <= stamp;
    req_ch.read_slot    <= slot;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // stop sending until every outstanding response has come back
  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (responses_owed != 0) @(negedge clk);
  endtask

  // random request; inserts dominate so the store fills and then spends most of
  // the run in the full state where the mean-distance scan picks the victim
  task automatic random_request();
    logic               func;
    logic [VAL_W-1:0]   value;
    logic [STAMP_W-1:0] stamp;
    logic [SLOT_W-1:0]  slot;
    func = ($urandom_range(0, 99) < 74) ? FUNC_INSERT : FUNC_READ;
    case ($urandom_range(0, 4))
      0: value = $urandom_range(0, 1) ? '1 : '0;                  // extremes
      1: value = VAL_W'(2040 + $urandom_range(0, 15));            // tight cluster
      2: value = $urandom_range(0, 1) ? VAL_W'(3000) : VAL_W'(1000); // equal distances
      default: value = VAL_W'($urandom_range(0, 4095));
    endcase
    case ($urandom_range(0, 19))
      0: stamp = '0;
      1: stamp = '1;
      default: stamp = $urandom();
    endcase
    case ($urandom_range(0, 6))
      0: slot = '0;
      1: slot = '1;
      default: slot = SLOT_W'($urandom_range(0, DEPTH - 1));
    endcase
    send_request(func, value, 1'(($urandom_range(0, 1))), stamp, slot);
  endtask

  // response side: random stall before each response, with calm stretches
  initial begin : response_side
    int  stall;
    bit  calm;
    calm = 1'b0;
    wait (rst == 1'b0);
    forever begin
      if ($urandom_range(0, 29) == 0) calm = !calm;
      stall = calm ? 0 : $urandom_range(0, 13);
      @(negedge clk);
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (rsp_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  initial begin : request_side
    send_calm = 1'b0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // directed: reads of an empty store come back as zeros
    send_request(FUNC_READ, '1, 1'b1, '1, '0);
    send_request(FUNC_READ, '0, 1'b0, '0, '1);
    // field extremes on insert; read_slot is ignored here
    send_request(FUNC_INSERT, '0, 1'b0, '0, '1);
    send_request(FUNC_INSERT, '1, 1'b1, '1, '0);
    // valid slots, then the slot at the fill count (still invalid)
    send_request(FUNC_READ, '0, 1'b0, '0, SLOT_W'(0));
    send_request(FUNC_READ, '0, 1'b0, '0, SLOT_W'(1));
    send_request(FUNC_READ, '0, 1'b0, '0, SLOT_W'(2));
    send_request(FUNC_INSERT, VAL_W'(2048), 1'b0, 32'ha5a5_a5a5, SLOT_W'(0));
    send_request(FUNC_READ, '1, 1'b1, '1, '1);
    // let the store go quiet once, then read back across the pause
    drain();
    send_request(FUNC_READ, '0, 1'b0, '0, SLOT_W'(2));
    send_request(FUNC_INSERT, VAL_W'(1), 1'b1, 32'h8000_0001, SLOT_W'(256));

    // random part; fills the store, then exercises replacement, ties and
    // overwrite bookkeeping of the sum
    for (int n = 0; n < RANDOM_REQS; n++) begin
      random_request();
      if ($urandom_range(0, 79) == 0) drain();
    end

    drain();
    // watch for stray responses for about one full-store insert
    repeat (600) @(posedge clk);
    if (mismatch_count == 0 && responses_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
